// ===== rtl/acss_pkg.sv =====
// Package: shared types, constants and codes of the channel scan scheduler.
package acss_pkg;

  // Channel plan
  localparam int NUM_CHANNELS = 14;
  localparam int CH_W         = 4;
  localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);

  // Register reset values
  localparam logic [3:0] SEARCH_SWEEPS_RESET = 4'd3;
  localparam logic [7:0] FOCUS_SWEEPS_RESET  = 8'd120;
  localparam logic [1:0] MISS_LIMIT_RESET    = 2'd3;

  // Configuration bus
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_SEARCH_SWEEPS = 2'd0,
    REG_FOCUS_SWEEPS  = 2'd1,
    REG_MISS_LIMIT    = 2'd2
  } reg_idx_t;

  // Scan phase codes
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_FOCUS  = 2'd1,
    PH_INTER  = 2'd2
  } phase_t;

  // Action codes of a command transaction
  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_REPORT  = 1'b1;

  typedef struct packed {
    logic [3:0] search_sweeps;
    logic [7:0] focus_sweeps;
    logic [1:0] miss_limit;
  } cfg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_FIND,
    ST_ROT,
    ST_DONE,
    ST_REL,
    ST_DECIDE,
    ST_OUT
  } state_t;

  // Channel search flavor
  typedef enum logic {
    FIND_ABOVE,
    FIND_LOW
  } find_mode_t;

endpackage

// ===== rtl/acss_cmd_if.sv =====
// Interface: command channel (advance or reception report).
interface acss_cmd_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [acss_pkg::CH_W-1:0] rx_channel;

  modport source (output valid, action, rx_channel, input ready);
  modport sink   (input valid, action, rx_channel, output ready);
endinterface

// ===== rtl/acss_res_if.sv =====
// Interface: result channel (channel to tune and phase).
interface acss_res_if;
  logic                      valid;
  logic                      ready;
  logic [acss_pkg::CH_W-1:0] channel;
  logic [1:0]                phase;

  modport source (output valid, channel, phase, input ready);
  modport sink   (input valid, channel, phase, output ready);
endinterface

// ===== rtl/acss_regs.sv =====
// Configuration register file behind the APB-style port.
module acss_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [acss_pkg::PADDR_W-1:0]   paddr,
  input  logic [acss_pkg::PDATA_W-1:0]   pwdata,
  output logic [acss_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output acss_pkg::cfg_t                 cfg
);

  acss_pkg::reg_idx_t reg_sel;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_sel = acss_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.search_sweeps <= acss_pkg::SEARCH_SWEEPS_RESET;
      cfg.focus_sweeps  <= acss_pkg::FOCUS_SWEEPS_RESET;
      cfg.miss_limit    <= acss_pkg::MISS_LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        acss_pkg::REG_SEARCH_SWEEPS: cfg.search_sweeps <= pwdata[3:0];
        acss_pkg::REG_FOCUS_SWEEPS:  cfg.focus_sweeps  <= pwdata[7:0];
        acss_pkg::REG_MISS_LIMIT:    cfg.miss_limit    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (reg_sel)
      acss_pkg::REG_SEARCH_SWEEPS: prdata[3:0] = cfg.search_sweeps;
      acss_pkg::REG_FOCUS_SWEEPS:  prdata[7:0] = cfg.focus_sweeps;
      acss_pkg::REG_MISS_LIMIT:    prdata[1:0] = cfg.miss_limit;
      default:                     prdata      = '0;
    endcase
  end

endmodule

// ===== rtl/adaptive_channel_scan_scheduler_unit.sv =====
// Top level: adaptive channel scan scheduler with a serial channel scan unit.
//
// A reception report is absorbed in the cycle it is accepted and gives no result. An advance
// gives one result: a small sequencer drives one channel scan unit that looks at one channel
// per cycle, and that unit serves the search for the next remembered channel, the rotation over
// remembered channels in interleaved search and the release check at the end of an interleaved
// round. The command side is ready only while the sequencer is idle. The result sits in an
// output register, so the next command is taken while a result waits.
module adaptive_channel_scan_scheduler_unit (
  input  logic                           clk,
  input  logic                           rst,
  acss_cmd_if.sink                       cmd,
  acss_res_if.source                     res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [acss_pkg::PADDR_W-1:0]   paddr,
  input  logic [acss_pkg::PDATA_W-1:0]   pwdata,
  output logic [acss_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int N  = acss_pkg::NUM_CHANNELS;
  localparam int CW = acss_pkg::CH_W;
  localparam int IW = acss_pkg::CH_IDX_W;

  acss_pkg::cfg_t cfg;

  acss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Architectural state
  acss_pkg::state_t     state, state_next;
  acss_pkg::phase_t     phase, phase_next;
  logic [CW-1:0]        cur, cur_next;
  logic [7:0]           sweep_cnt, sweep_cnt_next;
  logic [CW-1:0]        slot_div, slot_div_next;
  logic [1:0]           slot_mod, slot_mod_next;
  logic [CW-1:0]        rot, rot_next;
  logic [N-1:0]         remembered, remembered_next;
  logic [N-1:0]         seen, seen_next;
  logic [1:0]           miss [N];
  logic [1:0]           miss_next [N];
  logic                 activity, activity_next;

  // Sequencer working registers
  logic [CW-1:0]        tune_ch, tune_ch_next;
  logic                 done, done_next;
  logic [CW-1:0]        idx, idx_next;
  acss_pkg::find_mode_t find_mode, find_mode_next;
  acss_pkg::state_t     find_ret, find_ret_next;

  // Output register
  logic                 out_valid, out_valid_next;
  logic [CW-1:0]        out_channel, out_channel_next;
  logic [1:0]           out_phase, out_phase_next;

  // Derived terms
  logic                 cmd_acc;
  logic                 rx_in_range;
  logic [CW-1:0]        rx_m1;
  logic [CW-1:0]        idx_m1;
  logic                 idx_in_range;
  logic                 idx_hit;
  logic [CW-1:0]        rot_step;
  logic [CW-1:0]        rot_step_m1;
  logic                 rot_hit;
  logic                 step_done;
  logic [7:0]           cnt_inc;
  logic [7:0]           cnt_target;
  logic                 cnt_hit;
  logic [1:0]           miss_lim;
  logic [1:0]           miss_inc;
  logic                 out_load;

  assign cmd_acc      = cmd.valid && cmd.ready;
  assign cmd.ready    = (state == acss_pkg::ST_IDLE);
  assign rx_in_range  = (cmd.rx_channel != '0) && (cmd.rx_channel <= CW'(N));
  assign rx_m1        = cmd.rx_channel - CW'(1);

  // Channel scan unit: one channel per cycle
  assign idx_m1       = idx - CW'(1);
  assign idx_in_range = (idx != '0) && (idx <= CW'(N));
  assign idx_hit      = idx_in_range && remembered[idx_m1[IW-1:0]];

  // Rotation step, position stays in 1..N
  assign rot_step     = (rot >= CW'(N)) ? CW'(1) : rot + CW'(1);
  assign rot_step_m1  = rot_step - CW'(1);
  assign rot_hit      = remembered[rot_step_m1[IW-1:0]];

  // End of sweep for the current step
  always_comb begin
    case (phase)
      acss_pkg::PH_SEARCH: step_done = (cur >= CW'(N));
      acss_pkg::PH_FOCUS:  step_done = 1'b0;
      default:             step_done = (slot_div == CW'(N - 1)) && (slot_mod == 2'd2);
    endcase
  end

  // Sweep counter compare
  assign cnt_inc    = sweep_cnt + 8'd1;
  assign cnt_target = (phase == acss_pkg::PH_FOCUS) ? cfg.focus_sweeps
                                                    : {4'd0, cfg.search_sweeps};
  assign cnt_hit    = (cnt_inc >= cnt_target) || (cnt_inc == 8'd0);

  // Release check terms for the channel under the scan index
  assign miss_lim = (cfg.miss_limit == 2'd0) ? 2'd1 : cfg.miss_limit;
  assign miss_inc = miss[idx_m1[IW-1:0]] + 2'd1;

  assign out_load = (state == acss_pkg::ST_OUT) && (!out_valid || res.ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      acss_pkg::ST_IDLE: begin
        if (cmd_acc && (cmd.action == acss_pkg::ACT_ADVANCE)) state_next = acss_pkg::ST_STEP;
      end
      acss_pkg::ST_STEP: begin
        case (phase)
          acss_pkg::PH_SEARCH:
            state_next = step_done ? acss_pkg::ST_DONE : acss_pkg::ST_OUT;
          acss_pkg::PH_FOCUS:
            state_next = acss_pkg::ST_FIND;
          default: begin
            if ((slot_mod != 2'd0) && (remembered != '0)) state_next = acss_pkg::ST_ROT;
            else state_next = step_done ? acss_pkg::ST_DONE : acss_pkg::ST_OUT;
          end
        endcase
      end
      acss_pkg::ST_FIND: begin
        if (idx_hit) begin
          state_next = (find_mode == acss_pkg::FIND_ABOVE) ? acss_pkg::ST_OUT : find_ret;
        end else if (!idx_in_range && (find_mode == acss_pkg::FIND_LOW)) begin
          state_next = find_ret;
        end
      end
      acss_pkg::ST_ROT: begin
        if (rot_hit) state_next = done ? acss_pkg::ST_DONE : acss_pkg::ST_OUT;
      end
      acss_pkg::ST_DONE: begin
        if (!cnt_hit) begin
          state_next = acss_pkg::ST_OUT;
        end else begin
          case (phase)
            acss_pkg::PH_SEARCH:
              state_next = (remembered != '0) ? acss_pkg::ST_FIND : acss_pkg::ST_OUT;
            acss_pkg::PH_FOCUS:
              state_next = acss_pkg::ST_OUT;
            default:
              state_next = acss_pkg::ST_REL;
          endcase
        end
      end
      acss_pkg::ST_REL: begin
        if (idx == CW'(N)) state_next = acss_pkg::ST_DECIDE;
      end
      acss_pkg::ST_DECIDE: begin
        state_next = ((remembered == '0) || !activity) ? acss_pkg::ST_OUT : acss_pkg::ST_FIND;
      end
      acss_pkg::ST_OUT: begin
        if (out_load) state_next = acss_pkg::ST_IDLE;
      end
      default: state_next = acss_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output updates
  always_comb begin
    phase_next      = phase;
    cur_next        = cur;
    sweep_cnt_next  = sweep_cnt;
    slot_div_next   = slot_div;
    slot_mod_next   = slot_mod;
    rot_next        = rot;
    remembered_next = remembered;
    seen_next       = seen;
    miss_next       = miss;
    activity_next   = activity;
    tune_ch_next    = tune_ch;
    done_next       = done;
    idx_next        = idx;
    find_mode_next  = find_mode;
    find_ret_next   = find_ret;
    out_valid_next  = out_valid && !res.ready;
    out_channel_next = out_channel;
    out_phase_next   = out_phase;

    case (state)
      // Report: mark the channel, no result
      acss_pkg::ST_IDLE: begin
        if (cmd_acc && (cmd.action == acss_pkg::ACT_REPORT) && rx_in_range) begin
          remembered_next[rx_m1[IW-1:0]] = 1'b1;
          seen_next[rx_m1[IW-1:0]]       = 1'b1;
          if (phase == acss_pkg::PH_INTER) activity_next = 1'b1;
        end
      end
      // Pick the candidate channel for this phase
      acss_pkg::ST_STEP: begin
        done_next = step_done;
        case (phase)
          acss_pkg::PH_SEARCH: begin
            tune_ch_next = step_done ? CW'(1) : cur + CW'(1);
          end
          acss_pkg::PH_FOCUS: begin
            idx_next       = cur + CW'(1);
            find_mode_next = acss_pkg::FIND_ABOVE;
            find_ret_next  = acss_pkg::ST_DONE;
          end
          default: begin
            // fresh channel; also the fallback for an empty rotation
            tune_ch_next = slot_div + CW'(1);
            if (step_done) begin
              slot_div_next = '0;
              slot_mod_next = 2'd0;
            end else if (slot_mod == 2'd2) begin
              slot_div_next = slot_div + CW'(1);
              slot_mod_next = 2'd0;
            end else begin
              slot_mod_next = slot_mod + 2'd1;
            end
          end
        endcase
      end
      // Scan upward for a remembered channel
      acss_pkg::ST_FIND: begin
        if (idx_hit) begin
          tune_ch_next = idx;
        end else if (!idx_in_range) begin
          if (find_mode == acss_pkg::FIND_ABOVE) begin
            // wrapped past the top: sweep complete, restart from the lowest
            done_next      = 1'b1;
            idx_next       = CW'(1);
            find_mode_next = acss_pkg::FIND_LOW;
          end else begin
            tune_ch_next = CW'(1);
          end
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      // Rotate to the next remembered channel
      acss_pkg::ST_ROT: begin
        rot_next = rot_step;
        if (rot_hit) tune_ch_next = rot_step;
      end
      // Sweep completed: count and decide on a phase change
      acss_pkg::ST_DONE: begin
        if (!cnt_hit) begin
          sweep_cnt_next = cnt_inc;
        end else begin
          sweep_cnt_next = 8'd0;
          case (phase)
            acss_pkg::PH_SEARCH: begin
              if (remembered != '0) begin
                phase_next     = acss_pkg::PH_FOCUS;
                idx_next       = CW'(1);
                find_mode_next = acss_pkg::FIND_LOW;
                find_ret_next  = acss_pkg::ST_OUT;
              end
            end
            acss_pkg::PH_FOCUS: begin
              phase_next    = acss_pkg::PH_INTER;
              activity_next = 1'b0;
              tune_ch_next  = CW'(1);
              slot_div_next = '0;
              slot_mod_next = 2'd1;
            end
            default: begin
              idx_next = CW'(1);
            end
          endcase
        end
      end
      // Release check, one channel per cycle
      acss_pkg::ST_REL: begin
        if (remembered[idx_m1[IW-1:0]]) begin
          if (seen[idx_m1[IW-1:0]]) begin
            miss_next[idx_m1[IW-1:0]] = 2'd0;
            seen_next[idx_m1[IW-1:0]] = 1'b0;
          end else if ((miss_inc >= miss_lim) || (miss_inc == 2'd0)) begin
            remembered_next[idx_m1[IW-1:0]] = 1'b0;
            miss_next[idx_m1[IW-1:0]]       = 2'd0;
            seen_next[idx_m1[IW-1:0]]       = 1'b0;
          end else begin
            miss_next[idx_m1[IW-1:0]] = miss_inc;
          end
        end
        idx_next = idx + CW'(1);
      end
      // Back to search when nothing was heard or nothing is remembered, else focus again
      acss_pkg::ST_DECIDE: begin
        if ((remembered == '0) || !activity) begin
          phase_next   = acss_pkg::PH_SEARCH;
          tune_ch_next = CW'(1);
        end else begin
          phase_next     = acss_pkg::PH_FOCUS;
          idx_next       = CW'(1);
          find_mode_next = acss_pkg::FIND_LOW;
          find_ret_next  = acss_pkg::ST_OUT;
        end
      end
      // Hand the result to the output register
      acss_pkg::ST_OUT: begin
        if (out_load) begin
          cur_next         = tune_ch;
          out_valid_next   = 1'b1;
          out_channel_next = tune_ch;
          out_phase_next   = phase;
        end
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= acss_pkg::ST_IDLE;
      phase      <= acss_pkg::PH_SEARCH;
      cur        <= '0;
      sweep_cnt  <= 8'd0;
      slot_div   <= '0;
      slot_mod   <= 2'd0;
      rot        <= CW'(1);
      remembered <= '0;
      seen       <= '0;
      for (int i = 0; i < N; i++) miss[i] <= 2'd0;
      activity   <= 1'b0;
      done       <= 1'b0;
      find_mode  <= acss_pkg::FIND_ABOVE;
      find_ret   <= acss_pkg::ST_OUT;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      cur        <= cur_next;
      sweep_cnt  <= sweep_cnt_next;
      slot_div   <= slot_div_next;
      slot_mod   <= slot_mod_next;
      rot        <= rot_next;
      remembered <= remembered_next;
      seen       <= seen_next;
      miss       <= miss_next;
      activity   <= activity_next;
      done       <= done_next;
      find_mode  <= find_mode_next;
      find_ret   <= find_ret_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tune_ch     <= tune_ch_next;
    idx         <= idx_next;
    out_channel <= out_channel_next;
    out_phase   <= out_phase_next;
  end

  assign res.valid   = out_valid;
  assign res.channel = out_channel;
  assign res.phase   = out_phase;

  // Checks
  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    (rot >= CW'(1)) && (rot <= CW'(N)))
    else $error("rotation position left the channel range");

  a_focus_has_channels: assert property (@(posedge clk) disable iff (rst)
    (phase == acss_pkg::PH_FOCUS) |-> (remembered != '0))
    else $error("focus phase without remembered channels");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (slot_mod != 2'd3) && (slot_div < CW'(N)))
    else $error("interleave slot out of range");

  a_report_no_work: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && (cmd.action == acss_pkg::ACT_REPORT)) |=> (state == acss_pkg::ST_IDLE))
    else $error("report transaction started the sequencer");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_channel >= CW'(1)) && (out_channel <= CW'(N))))
    else $error("result channel out of range");

endmodule

// ===== test/tb_adaptive_channel_scan_scheduler_unit.sv =====
// Testbench: self-checking stimulus and channel prediction for the channel scan scheduler.
module tb_adaptive_channel_scan_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import acss_pkg::*;

  typedef struct {
    logic             action;
    logic [CH_W-1:0]  rx_channel;
  } sched_cmd_t;

  typedef struct {
    logic [CH_W-1:0]  channel;
    phase_t           phase;
  } tune_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SNK,
    IDLE_BOTH
  } idle_mode_t;

  // Settle time after draining, with margin over the longest advance
  localparam int SETTLE_CYCLES = 3 * NUM_CHANNELS + 20;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  acss_cmd_if cmd_if ();
  acss_res_if res_if ();

  adaptive_channel_scan_scheduler_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if.sink),
    .res     (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus and checking state
  sched_cmd_t  cmd_backlog_q[$];
  tune_t       tune_expect_q[$];
  sched_cmd_t  cmd_in_flight;
  int          src_idle_pct;
  int          snk_stall_pct;
  int          n_errors;

  // Predictor copy of the configuration
  logic [3:0]  cfg_search;
  logic [7:0]  cfg_focus;
  logic [1:0]  cfg_miss;

  // Predictor copy of the scheduler state
  logic [CH_W-1:0]          cur_ch;
  phase_t                   cur_phase;
  logic [7:0]               sweep_cnt;
  int                       slot_pos;
  logic [CH_W-1:0]          rot_pos;
  logic [NUM_CHANNELS-1:0]  rem_mask;
  logic [NUM_CHANNELS-1:0]  seen_mask;
  logic [1:0]               miss_cnt [NUM_CHANNELS];
  bit                       activity;

  // Clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void sched_reset();
    cfg_search = SEARCH_SWEEPS_RESET;
    cfg_focus  = FOCUS_SWEEPS_RESET;
    cfg_miss   = MISS_LIMIT_RESET;
    cur_ch     = '0;
    cur_phase  = PH_SEARCH;
    sweep_cnt  = '0;
    slot_pos   = 0;
    rot_pos    = 4'd1;
    rem_mask   = '0;
    seen_mask  = '0;
    activity   = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) miss_cnt[i] = '0;
  endfunction

  function automatic bit is_remembered(int ch);
    if (ch < 1 || ch > NUM_CHANNELS) return 1'b0;
    return rem_mask[ch-1];
  endfunction

  // Lowest remembered channel above 'after', 0 when none
  function automatic int lowest_remembered_above(int after);
    for (int c = after + 1; c <= NUM_CHANNELS; c++)
      if (is_remembered(c)) return c;
    return 0;
  endfunction

  // Next remembered channel in rotation order, 0 when none
  function automatic int rotate_remembered();
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      rot_pos = rot_pos + 4'd1;
      if (rot_pos > NUM_CHANNELS || rot_pos < 1) rot_pos = 4'd1;
      if (is_remembered(rot_pos)) return rot_pos;
    end
    return 0;
  endfunction

  // End of interleaved round: clear seen channels, age and drop silent ones
  function automatic void release_silent();
    int lim;
    lim = (cfg_miss == 2'd0) ? 1 : cfg_miss;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (!rem_mask[c]) continue;
      if (seen_mask[c]) begin
        miss_cnt[c]  = '0;
        seen_mask[c] = 1'b0;
      end else begin
        miss_cnt[c] = miss_cnt[c] + 2'd1;
        if (miss_cnt[c] >= lim || miss_cnt[c] == 2'd0) begin
          rem_mask[c]  = 1'b0;
          miss_cnt[c]  = '0;
          seen_mask[c] = 1'b0;
        end
      end
    end
  endfunction

  // Apply one accepted command; returns 1 with the tuning result for an advance
  function automatic bit next_tuning(input sched_cmd_t c, output tune_t r);
    int  ch;
    int  nxt;
    int  fresh;
    int  target;
    bit  done;
    ch   = c.rx_channel;
    nxt  = 0;
    done = 1'b0;
    r.channel = '0;
    r.phase   = PH_SEARCH;

    if (c.action == ACT_REPORT) begin
      if (ch >= 1 && ch <= NUM_CHANNELS) begin
        rem_mask[ch-1]  = 1'b1;
        seen_mask[ch-1] = 1'b1;
        if (cur_phase == PH_INTER) activity = 1'b1;
      end
      return 1'b0;
    end

    case (cur_phase)
      PH_SEARCH: begin
        nxt = cur_ch + 1;
        if (nxt > NUM_CHANNELS) begin
          nxt  = 1;
          done = 1'b1;
        end
      end
      PH_FOCUS: begin
        nxt = lowest_remembered_above(cur_ch);
        if (nxt == 0) begin
          done = 1'b1;
          nxt  = lowest_remembered_above(0);
          if (nxt == 0) nxt = 1;
        end
      end
      default: begin
        fresh = slot_pos / 3 + 1;
        if (slot_pos % 3 == 0) begin
          nxt = fresh;
        end else begin
          nxt = rotate_remembered();
          if (nxt == 0) nxt = fresh;
        end
        slot_pos++;
        if (slot_pos >= 3 * NUM_CHANNELS) begin
          slot_pos = 0;
          done     = 1'b1;
        end
      end
    endcase

    // Sweep finished: count it and decide on a phase change
    if (done) begin
      target    = (cur_phase == PH_FOCUS) ? cfg_focus : cfg_search;
      sweep_cnt = sweep_cnt + 8'd1;
      if (sweep_cnt >= target || sweep_cnt == 8'd0) begin
        sweep_cnt = '0;
        case (cur_phase)
          PH_SEARCH: begin
            if (rem_mask != '0) begin
              cur_phase = PH_FOCUS;
              nxt       = lowest_remembered_above(0);
            end
          end
          PH_FOCUS: begin
            cur_phase = PH_INTER;
            activity  = 1'b0;
            nxt       = 1;
            slot_pos  = 1;
          end
          default: begin
            release_silent();
            if (rem_mask == '0 || !activity) begin
              cur_phase = PH_SEARCH;
              nxt       = 1;
            end else begin
              cur_phase = PH_FOCUS;
              nxt       = lowest_remembered_above(0);
              if (nxt == 0) nxt = 1;
            end
          end
        endcase
      end
    end

    cur_ch    = nxt[CH_W-1:0];
    r.channel = cur_ch;
    r.phase   = cur_phase;
    return 1'b1;
  endfunction

  // Command driver: predict on acceptance, then offer the next backlog entry
  always @(posedge clk) begin
    tune_t t;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        if (next_tuning(cmd_in_flight, t)) tune_expect_q.push_back(t);
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_backlog_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cmd_in_flight      = cmd_backlog_q.pop_front();
          cmd_if.valid      <= 1'b1;
          cmd_if.action     <= cmd_in_flight.action;
          cmd_if.rx_channel <= cmd_in_flight.rx_channel;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted transaction with the oldest expectation
  always @(posedge clk) begin
    tune_t t;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (tune_expect_q.size() == 0) begin
          $error("unexpected result: channel %0d phase %0d", res_if.channel, res_if.phase);
          n_errors++;
        end else begin
          t = tune_expect_q.pop_front();
          if (res_if.channel !== t.channel) begin
            $error("channel mismatch: expected %0d, actual %0d", t.channel, res_if.channel);
            n_errors++;
          end
          if (res_if.phase !== t.phase) begin
            $error("phase mismatch: expected %0d, actual %0d", t.phase, res_if.phase);
            n_errors++;
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // APB write: setup cycle, then access cycle; register takes the value at its end
  task automatic cfg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SEARCH_SWEEPS: cfg_search = val[3:0];
      REG_FOCUS_SWEEPS:  cfg_focus  = val[7:0];
      default:           cfg_miss   = val[1:0];
    endcase
  endtask

  function automatic void set_idle(idle_mode_t m);
    case (m)
      IDLE_NONE: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      IDLE_SRC:  begin src_idle_pct = 75; snk_stall_pct = 0;  end
      IDLE_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 75; end
      default:   begin src_idle_pct = 15; snk_stall_pct = 15; end
    endcase
  endfunction

  function automatic void push_cmd(logic action, logic [CH_W-1:0] rx);
    sched_cmd_t c;
    c.action     = action;
    c.rx_channel = rx;
    cmd_backlog_q.push_back(c);
  endfunction

  // Wait until every transaction is sent and answered, then let the block settle
  task automatic drain();
    while (cmd_backlog_q.size() != 0 || cmd_if.valid || tune_expect_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One setting: program registers, then a random mix of advances and reports
  task automatic run_setting(input logic [3:0] ss, input logic [7:0] fs,
                             input logic [1:0] ml, input idle_mode_t m,
                             input int rpt_pct, input int n_items);
    int r;
    int counted;
    cfg_write(REG_SEARCH_SWEEPS, {28'd0, ss});
    cfg_write(REG_FOCUS_SWEEPS, {24'd0, fs});
    cfg_write(REG_MISS_LIMIT, {30'd0, ml});
    set_idle(m);
    counted = 0;
    while (counted < n_items) begin
      r = $urandom_range(99);
      if (r < rpt_pct) begin
        push_cmd(ACT_REPORT, 4'($urandom_range(1, NUM_CHANNELS)));
        counted++;
      end else if (r < rpt_pct + 4) begin
        // out-of-range report, ignored by the block
        push_cmd(ACT_REPORT, ($urandom_range(1) != 0) ? 4'd0 : 4'd15);
      end else begin
        // rx_channel is a don't-care on advances; drive noise there
        push_cmd(ACT_ADVANCE, 4'($urandom_range(15)));
        counted++;
      end
    end
    drain();
  endtask

  // Watchdog
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Main sequence
  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cmd_if.valid      = 1'b0;
    cmd_if.action     = ACT_ADVANCE;
    cmd_if.rx_channel = '0;
    res_if.ready      = 1'b0;
    n_errors          = 0;
    sched_reset();
    set_idle(IDLE_NONE);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, field extremes, ignored reports, both actions
    push_cmd(ACT_REPORT, 4'd0);
    push_cmd(ACT_REPORT, 4'd15);
    push_cmd(ACT_ADVANCE, 4'd15);
    push_cmd(ACT_ADVANCE, 4'd0);
    push_cmd(ACT_REPORT, 4'd1);
    push_cmd(ACT_REPORT, 4'd14);
    push_cmd(ACT_REPORT, 4'd8);
    for (int i = 0; i < 18; i++) push_cmd(ACT_ADVANCE, 4'($urandom_range(15)));
    drain();

    // Further settings, one drawn at random, extremes and zero registers among them
    run_setting(4'd1,  8'd1,   2'd1, IDLE_NONE, 20, 250);
    run_setting(4'd0,  8'd0,   2'd0, IDLE_SRC,  8,  250);
    run_setting(4'd15, 8'd255, 2'd3, IDLE_SNK,  10, 350);
    run_setting(4'd2,  8'd3,   2'd2, IDLE_BOTH, 25, 250);
    run_setting(4'd1,  8'd2,   2'd3, IDLE_NONE, 3,  250);
    run_setting(4'($urandom_range(1, 4)), 8'($urandom_range(1, 6)),
                2'($urandom_range(1, 3)), IDLE_BOTH, 15, 350);

    if (n_errors == 0 && tune_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
